// ----- design/msdt_pkg.sv -----
// ----------------------------------------------------------------------------
// msdt_pkg
// shared widths, constants and sequencer states of the deadline timer
// ----------------------------------------------------------------------------
`default_nettype none

package msdt_pkg;

   // tick counter and deadline width
   localparam int COUNT_WIDTH = 64;
   // dividend width of the shared divider
   localparam int DIV_WIDTH   = 64;
   localparam int STEP_WIDTH  = $clog2(DIV_WIDTH);
   localparam int FREQ_WIDTH  = 32;
   localparam int MS_WIDTH    = 32;

   localparam logic [FREQ_WIDTH-1:0] FREQ_RESET = FREQ_WIDTH'(1000000);
   localparam logic [FREQ_WIDTH-1:0] MS_PER_SEC = FREQ_WIDTH'(1000);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_DIV   = 6'b000010,
      ST_ADD   = 6'b000100,
      ST_CMP   = 6'b001000,
      ST_SCALE = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

endpackage

`default_nettype wire

// ----- design/msdt_req_if.sv -----
// ----------------------------------------------------------------------------
// msdt_req_if
// input item channel of the deadline timer: tick or arm
// ----------------------------------------------------------------------------
`default_nettype none

interface msdt_req_if;

   logic                         valid;
   logic                         ready;
   logic                         func;
   logic [msdt_pkg::MS_WIDTH-1:0] arm_ms;

   modport source (output valid, output func, output arm_ms, input ready);
   modport sink   (input valid, input func, input arm_ms, output ready);

endinterface

`default_nettype wire

// ----- design/msdt_rsp_if.sv -----
// ----------------------------------------------------------------------------
// msdt_rsp_if
// result item channel of the deadline timer: expired flag and time left
// ----------------------------------------------------------------------------
`default_nettype none

interface msdt_rsp_if;

   logic                         valid;
   logic                         ready;
   logic                         expired;
   logic [msdt_pkg::MS_WIDTH-1:0] remaining_ms;

   modport source (output valid, output expired, output remaining_ms, input ready);
   modport sink   (input valid, input expired, input remaining_ms, output ready);

endinterface

`default_nettype wire

// ----- design/ms_deadline_timer.sv -----
// ----------------------------------------------------------------------------
// ms_deadline_timer - one-shot deadline timer over a free-running tick counter
// tick counts, arm divides and adds; both then compare, and scale and divide unless expired
// throughput: one item at a time, set by the 64-step shared divider loop
// reset: synchronous; counter and deadline 0 (reads expired), freq 1000000
// ----------------------------------------------------------------------------
`default_nettype none

module ms_deadline_timer (
   input  wire logic                             clock,
   input  wire logic                             reset,
   msdt_req_if.sink                              req_ch,
   msdt_rsp_if.source                            rsp_ch,
   input  wire logic                             csr_we,
   input  wire logic [msdt_pkg::FREQ_WIDTH-1:0]  csr_wdata
);

   // sequencer
   msdt_pkg::state_type                 state_ff, state_in;
   logic [msdt_pkg::STEP_WIDTH-1:0]     step_ff, step_in;
   // set while the divider works out the arm span, clear for the time left
   logic                                arm_phase_ff, arm_phase_in;

   // timer state and the frequency register
   logic [msdt_pkg::COUNT_WIDTH-1:0]    count_ff, count_in;
   logic [msdt_pkg::COUNT_WIDTH-1:0]    deadline_ff, deadline_in;
   logic [msdt_pkg::FREQ_WIDTH-1:0]     freq_ff, freq_in;

   // shared restoring divider: dividend shifts out, quotient shifts in
   logic [msdt_pkg::DIV_WIDTH-1:0]      div_ff, div_in;
   logic [msdt_pkg::FREQ_WIDTH-1:0]     dsr_ff, dsr_in;
   logic [msdt_pkg::FREQ_WIDTH-1:0]     rem_ff, rem_in;

   // compare results
   logic [msdt_pkg::COUNT_WIDTH-1:0]    diff_ff, diff_in;
   logic                                expired_ff, expired_in;

   // output register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_expired_ff, rsp_expired_in;
   logic [msdt_pkg::MS_WIDTH-1:0]       rsp_ms_ff, rsp_ms_in;

   // datapath helpers
   logic [msdt_pkg::FREQ_WIDTH:0]       div_shift;
   logic                                div_ge;
   logic [msdt_pkg::FREQ_WIDTH-1:0]     div_sub;
   logic [msdt_pkg::COUNT_WIDTH:0]      cmp_sub;
   logic [msdt_pkg::DIV_WIDTH-1:0]      arm_prod;
   logic [msdt_pkg::DIV_WIDTH-1:0]      scaled;

   // one divider step: bring down the next dividend bit, subtract if it fits
   // a zero divisor always fits, giving an all-ones quotient
   assign div_shift = {rem_ff, div_ff[msdt_pkg::DIV_WIDTH-1]};
   assign div_ge    = div_shift >= {1'b0, dsr_ff};
   // the difference is below the divisor whenever it is kept
   assign div_sub   = div_shift[msdt_pkg::FREQ_WIDTH-1:0] - dsr_ff;

   // deadline minus counter; a borrow or a zero difference means expired
   assign cmp_sub = {1'b0, deadline_ff} - {1'b0, count_ff};

   // 32 x 32 product of frequency and delay, fits the 64-bit dividend
   assign arm_prod = msdt_pkg::DIV_WIDTH'(freq_ff) * msdt_pkg::DIV_WIDTH'(req_ch.arm_ms);

   // ticks left times 1000, wrapping at the dividend width
   assign scaled = msdt_pkg::DIV_WIDTH'(diff_ff) * msdt_pkg::DIV_WIDTH'(msdt_pkg::MS_PER_SEC);

   // only the idle sequencer takes an item
   assign req_ch.ready = (state_ff == msdt_pkg::ST_IDLE);

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.expired      = rsp_expired_ff;
   assign rsp_ch.remaining_ms = rsp_ms_ff;

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      arm_phase_in   = arm_phase_ff;
      count_in       = count_ff;
      deadline_in    = deadline_ff;
      freq_in        = freq_ff;
      div_in         = div_ff;
      dsr_in         = dsr_ff;
      rem_in         = rem_ff;
      diff_in        = diff_ff;
      expired_in     = expired_ff;
      rsp_expired_in = rsp_expired_ff;
      rsp_ms_in      = rsp_ms_ff;
      // a waiting result leaves once taken
      rsp_valid_in   = rsp_valid_ff & ~rsp_ch.ready;

      if (csr_we) begin
         freq_in = csr_wdata;
      end

      case (state_ff)
         msdt_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.func) begin
                  // arm: span = freq * ms / 1000 through the divider
                  div_in       = arm_prod;
                  dsr_in       = msdt_pkg::MS_PER_SEC;
                  rem_in       = '0;
                  step_in      = '0;
                  arm_phase_in = 1'b1;
                  state_in     = msdt_pkg::ST_DIV;
               end else begin
                  // tick: counter wraps at its width
                  count_in = count_ff + msdt_pkg::COUNT_WIDTH'(1);
                  state_in = msdt_pkg::ST_CMP;
               end
            end
         end

         msdt_pkg::ST_DIV: begin
            div_in  = {div_ff[msdt_pkg::DIV_WIDTH-2:0], div_ge};
            rem_in  = div_ge ? div_sub
                             : div_shift[msdt_pkg::FREQ_WIDTH-1:0];
            step_in = step_ff + msdt_pkg::STEP_WIDTH'(1);
            if (step_ff == msdt_pkg::STEP_WIDTH'(msdt_pkg::DIV_WIDTH - 1)) begin
               state_in = arm_phase_ff ? msdt_pkg::ST_ADD : msdt_pkg::ST_OUT;
            end
         end

         msdt_pkg::ST_ADD: begin
            // new deadline from the current counter, arm does not tick
            deadline_in = count_ff + div_ff[msdt_pkg::COUNT_WIDTH-1:0];
            state_in    = msdt_pkg::ST_CMP;
         end

         msdt_pkg::ST_CMP: begin
            diff_in    = cmp_sub[msdt_pkg::COUNT_WIDTH-1:0];
            expired_in = cmp_sub[msdt_pkg::COUNT_WIDTH]
                         | (cmp_sub[msdt_pkg::COUNT_WIDTH-1:0] == '0);
            state_in   = expired_in ? msdt_pkg::ST_OUT : msdt_pkg::ST_SCALE;
         end

         msdt_pkg::ST_SCALE: begin
            // time left: ticks * 1000 / freq
            div_in       = scaled;
            dsr_in       = freq_ff;
            rem_in       = '0;
            step_in      = '0;
            arm_phase_in = 1'b0;
            state_in     = msdt_pkg::ST_DIV;
         end

         msdt_pkg::ST_OUT: begin
            // hold here while an earlier result still waits
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_expired_in = expired_ff;
               rsp_ms_in      = expired_ff ? '0 : div_ff[msdt_pkg::MS_WIDTH-1:0];
               state_in       = msdt_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = msdt_pkg::ST_IDLE;
         end
      endcase
   end

   // control and timer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= msdt_pkg::ST_IDLE;
         step_ff      <= '0;
         arm_phase_ff <= 1'b0;
         count_ff     <= '0;
         deadline_ff  <= '0;
         freq_ff      <= msdt_pkg::FREQ_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         arm_phase_ff <= arm_phase_in;
         count_ff     <= count_in;
         deadline_ff  <= deadline_in;
         freq_ff      <= freq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      div_ff         <= div_in;
      dsr_ff         <= dsr_in;
      rem_ff         <= rem_in;
      diff_ff        <= diff_in;
      expired_ff     <= expired_in;
      rsp_expired_ff <= rsp_expired_in;
      rsp_ms_ff      <= rsp_ms_in;
   end

endmodule

`default_nettype wire

// ----- design/msdt_sva.sv -----
// ----------------------------------------------------------------------------
// msdt_sva
// port-level checks of the deadline timer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module msdt_sva (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic                          rsp_expired,
   input wire logic [msdt_pkg::MS_WIDTH-1:0] rsp_remaining_ms
);

   // no result straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // one item at a time: busy once an item is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item taken while busy");

   // an expired result reports no time left
   a_expired_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_expired) |-> (rsp_remaining_ms == '0))
      else $error("expired result with time left");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_expired) && $stable(rsp_remaining_ms)))
      else $error("stalled result changed");

endmodule

bind ms_deadline_timer msdt_sva u_msdt_sva (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_expired      (rsp_ch.expired),
   .rsp_remaining_ms (rsp_ch.remaining_ms)
);

`default_nettype wire
